### hdl/rwcp_pkg.sv
// Shared types and constants for the RIFF wave chunk parser.
package rwcp_pkg;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_JUNK = 32'h4B4E_554A;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY = 32'd16;

    localparam logic [1:0] KIND_DATA      = 2'd0;
    localparam logic [1:0] KIND_FORMAT    = 2'd1;
    localparam logic [1:0] KIND_FMT_SHORT = 2'd2;

    localparam logic [1:0] FORM_WAVE    = 2'd0;
    localparam logic [1:0] FORM_JUNK    = 2'd1;
    localparam logic [1:0] FORM_UNKNOWN = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  audio_byte;
        logic        last_of_chunk;
        logic [15:0] channel_count;
        logic [31:0] sample_rate;
        logic [15:0] sample_bits;
        logic [1:0]  format_code;
        logic        riff_ok;
        logic [1:0]  form_type;
    } result_t;

endpackage

### hdl/rwcp_ifs.sv
// Valid/ready channel interfaces for file bytes and parse results.
interface rwcp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] file_byte;
    logic       file_start;

    modport source (output valid, output file_byte, output file_start, input ready);
    modport sink   (input valid, input file_byte, input file_start, output ready);
endinterface

interface rwcp_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind;
    logic [7:0]  audio_byte;
    logic        last_of_chunk;
    logic [15:0] channel_count;
    logic [31:0] sample_rate;
    logic [15:0] sample_bits;
    logic [1:0]  format_code;
    logic        riff_ok;
    logic [1:0]  form_type;

    modport source (output valid, output kind, output audio_byte, output last_of_chunk,
                    output channel_count, output sample_rate, output sample_bits,
                    output format_code, output riff_ok, output form_type, input ready);
    modport sink   (input valid, input kind, input audio_byte, input last_of_chunk,
                    input channel_count, input sample_rate, input sample_bits,
                    input format_code, input riff_ok, input form_type, output ready);
endinterface

### hdl/rwcp_parser.sv
// Parse state registers and the per-byte header and chunk walking logic.
module rwcp_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        file_byte,
    input  logic              file_start,
    output logic              res_valid,
    output rwcp_pkg::result_t res
);

    typedef enum logic [4:0] {
        PH_HEADER = 5'b00001,
        PH_CHUNK  = 5'b00010,
        PH_SKIP   = 5'b00100,
        PH_FMT    = 5'b01000,
        PH_DATA   = 5'b10000
    } phase_t;

    phase_t      phase_reg, phase_next, cur_phase;
    logic [3:0]  pos_reg, pos_next, cur_pos, hdr_pos;
    logic [31:0] remain_reg, remain_next, cur_remain;
    logic [31:0] word_reg, word_next, word_base;
    logic [31:0] id_reg, id_next, cur_id;
    logic [15:0] chan_reg, chan_next;
    logic [31:0] rate_reg, rate_next;
    logic [15:0] bits_reg, bits_next;
    logic        riff_reg, riff_next;
    logic [1:0]  form_reg, form_next;

    always_comb
    begin
        cur_phase  = file_start ? PH_HEADER : phase_reg;
        cur_pos    = file_start ? 4'd0 : pos_reg;
        cur_remain = file_start ? 32'd0 : remain_reg;
        cur_id     = file_start ? 32'd0 : id_reg;
        word_base  = file_start ? 32'd0 : word_reg;
        word_next  = {file_byte, word_base[31:8]};
        hdr_pos    = (cur_pos > 4'd7) ? 4'd0 : cur_pos;

        phase_next  = cur_phase;
        pos_next    = cur_pos;
        remain_next = cur_remain;
        id_next     = cur_id;
        chan_next   = file_start ? 16'd0 : chan_reg;
        rate_next   = file_start ? 32'd0 : rate_reg;
        bits_next   = file_start ? 16'd0 : bits_reg;
        riff_next   = file_start ? 1'b0 : riff_reg;
        form_next   = file_start ? rwcp_pkg::FORM_WAVE : form_reg;

        res_valid = 1'b0;
        res       = '0;

        case (cur_phase)
            PH_HEADER:
            begin
                if (cur_pos == 4'd3)
                    riff_next = (word_next == rwcp_pkg::ID_RIFF);
                if (cur_pos >= 4'd11)
                begin
                    if (word_next == rwcp_pkg::ID_WAVE)
                        form_next = rwcp_pkg::FORM_WAVE;
                    else if (word_next == rwcp_pkg::ID_JUNK)
                        form_next = rwcp_pkg::FORM_JUNK;
                    else
                        form_next = rwcp_pkg::FORM_UNKNOWN;
                    phase_next = PH_CHUNK;
                    pos_next   = 4'd0;
                end
                else
                    pos_next = cur_pos + 4'd1;
            end
            PH_SKIP, PH_DATA:
            begin
                if (cur_phase == PH_DATA)
                begin
                    res_valid         = 1'b1;
                    res.kind          = rwcp_pkg::KIND_DATA;
                    res.audio_byte    = file_byte;
                    res.last_of_chunk = (cur_remain == 32'd1);
                end
                if (cur_remain <= 32'd1)
                begin
                    remain_next = 32'd0;
                    phase_next  = PH_CHUNK;
                    pos_next    = 4'd0;
                end
                else
                    remain_next = cur_remain - 32'd1;
            end
            PH_FMT:
            begin
                if (cur_pos == 4'd3)
                    chan_next = word_next[31:16];
                if (cur_pos == 4'd7)
                    rate_next = word_next;
                if (cur_pos >= 4'd15)
                begin
                    bits_next         = word_next[31:16];
                    res_valid         = 1'b1;
                    res.kind          = rwcp_pkg::KIND_FORMAT;
                    res.channel_count = chan_next;
                    res.sample_rate   = rate_next;
                    res.sample_bits   = bits_next;
                    res.format_code   = {chan_next != 16'd1, bits_next != 16'd8};
                    remain_next       = cur_remain - rwcp_pkg::FMT_BODY;
                    phase_next        = (remain_next != 32'd0) ? PH_SKIP : PH_CHUNK;
                    pos_next          = 4'd0;
                end
                else
                    pos_next = cur_pos + 4'd1;
            end
            default:
            begin
                phase_next = PH_CHUNK;
                pos_next   = hdr_pos + 4'd1;
                if (hdr_pos == 4'd3)
                    id_next = word_next;
                if (hdr_pos == 4'd7)
                begin
                    pos_next    = 4'd0;
                    remain_next = word_next;
                    if (cur_id == rwcp_pkg::ID_FMT)
                    begin
                        if (word_next < rwcp_pkg::FMT_BODY)
                        begin
                            res_valid  = 1'b1;
                            res.kind   = rwcp_pkg::KIND_FMT_SHORT;
                            phase_next = (word_next != 32'd0) ? PH_SKIP : PH_CHUNK;
                        end
                        else
                            phase_next = PH_FMT;
                    end
                    else if (cur_id == rwcp_pkg::ID_DATA)
                        phase_next = (word_next != 32'd0) ? PH_DATA : PH_CHUNK;
                    else
                        phase_next = (word_next != 32'd0) ? PH_SKIP : PH_CHUNK;
                end
            end
        endcase

        res.riff_ok   = riff_next;
        res.form_type = form_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            pos_reg    <= 4'd0;
            remain_reg <= 32'd0;
            word_reg   <= 32'd0;
            id_reg     <= 32'd0;
            chan_reg   <= 16'd0;
            rate_reg   <= 32'd0;
            bits_reg   <= 16'd0;
            riff_reg   <= 1'b0;
            form_reg   <= rwcp_pkg::FORM_WAVE;
        end
        else if (take)
        begin
            phase_reg  <= phase_next;
            pos_reg    <= pos_next;
            remain_reg <= remain_next;
            word_reg   <= word_next;
            id_reg     <= id_next;
            chan_reg   <= chan_next;
            rate_reg   <= rate_next;
            bits_reg   <= bits_next;
            riff_reg   <= riff_next;
            form_reg   <= form_next;
        end
    end

endmodule

### hdl/rwcp_out_stage.sv
// Result register with flow control back to the byte channel.
module rwcp_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              res_valid,
    input  rwcp_pkg::result_t res,
    output logic              out_valid,
    input  logic              out_ready,
    output rwcp_pkg::result_t out_data
);

    logic              valid_reg, valid_next;
    rwcp_pkg::result_t data_reg;
    logic              take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
            valid_next = res_valid;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
            data_reg <= res;
    end

endmodule

### hdl/riff_wave_chunk_parser.sv
// Top level: RIFF/WAVE byte-stream parser giving format and audio-byte results.
// Latency: a result is shown in the cycle after the byte that causes it is accepted.
// Throughput: one byte per cycle; a byte is taken whenever the result register is
// empty or is being drained, so a result stalled by the receiver holds off the next byte.
// Reset clears the parse state to the start of a file and empties the result register.
module riff_wave_chunk_parser (
    input  logic                 clk,
    input  logic                 rst_n,
    rwcp_byte_if.sink            file_stream,
    rwcp_result_if.source        result_stream
);

    logic              take;
    logic              res_valid;
    rwcp_pkg::result_t res;
    rwcp_pkg::result_t out_data;

    assign take = file_stream.valid && file_stream.ready;

    rwcp_parser u_parser (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .file_byte  (file_stream.file_byte),
        .file_start (file_stream.file_start),
        .res_valid  (res_valid),
        .res        (res)
    );

    rwcp_out_stage u_out_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (file_stream.valid),
        .in_ready  (file_stream.ready),
        .res_valid (res_valid),
        .res       (res),
        .out_valid (result_stream.valid),
        .out_ready (result_stream.ready),
        .out_data  (out_data)
    );

    assign result_stream.kind          = out_data.kind;
    assign result_stream.audio_byte    = out_data.audio_byte;
    assign result_stream.last_of_chunk = out_data.last_of_chunk;
    assign result_stream.channel_count = out_data.channel_count;
    assign result_stream.sample_rate   = out_data.sample_rate;
    assign result_stream.sample_bits   = out_data.sample_bits;
    assign result_stream.format_code   = out_data.format_code;
    assign result_stream.riff_ok       = out_data.riff_ok;
    assign result_stream.form_type     = out_data.form_type;

endmodule

### hdl/rwcp_checker.sv
// Port-level checks on the parser's channels, bound to the top level.
module rwcp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] kind,
    input logic [7:0] audio_byte,
    input logic       last_of_chunk
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("byte refused with empty result register");

    a_result_from_request: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready))
        else $error("result without an accepted request");

    a_non_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != rwcp_pkg::KIND_DATA |-> audio_byte == 8'd0 && !last_of_chunk
            && (kind == rwcp_pkg::KIND_FORMAT || kind == rwcp_pkg::KIND_FMT_SHORT))
        else $error("bad non-data result");

endmodule

bind riff_wave_chunk_parser rwcp_checker u_rwcp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (file_stream.valid),
    .in_ready      (file_stream.ready),
    .out_valid     (result_stream.valid),
    .out_ready     (result_stream.ready),
    .kind          (result_stream.kind),
    .audio_byte    (result_stream.audio_byte),
    .last_of_chunk (result_stream.last_of_chunk)
);
